// ===== src/mlbd_pkg.sv =====
package mlbd_pkg;

  // Default and fixed limits of the source image
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int ROW_W         = 10;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

  // One texel, red in the lowest byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } texel_t;

  // Horizontal pair sums, red in the lowest nine bits
  typedef struct packed {
    logic [8:0] alpha;
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } pair_t;

  // What an accepted texel leaves for the output stage
  typedef struct packed {
    logic emit;
    logic last;
  } issue_t;

endpackage

// ===== src/mlbd_line_ram.sv =====
module mlbd_line_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  mlbd_pkg::pair_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output mlbd_pkg::pair_t     rd_data
);
  import mlbd_pkg::*;

  pair_t mem [DEPTH];

  // Write pair sums of even rows
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mlbd_pair_front.sv =====
module mlbd_pair_front #(
  parameter int COL_W  = 10,
  parameter int ADDR_W = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  mlbd_pkg::texel_t            texel,
  input  logic                        restart,
  input  logic [COL_W-1:0]            col_last,
  input  logic [mlbd_pkg::ROW_W-1:0]  row_last,
  output mlbd_pkg::issue_t            issue,
  output mlbd_pkg::pair_t             pair,
  output logic                        wr_en,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           slot
);
  import mlbd_pkg::*;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  texel_t           held_left_texel;
  logic             odd_col;
  logic             odd_row;

  assign odd_col = column_count[0];
  assign odd_row = row_count[0];
  assign slot    = ADDR_W'(column_count >> 1);

  // Add the held left texel to the new right texel
  always_comb begin
    pair.red   = {1'b0, held_left_texel.red}   + {1'b0, texel.red};
    pair.green = {1'b0, held_left_texel.green} + {1'b0, texel.green};
    pair.blue  = {1'b0, held_left_texel.blue}  + {1'b0, texel.blue};
    pair.alpha = {1'b0, held_left_texel.alpha} + {1'b0, texel.alpha};
  end

  // Store pairs on even rows, fetch the row above on odd rows
  assign wr_en      = accept && odd_col && !odd_row;
  assign rd_en      = accept && odd_col && odd_row;
  assign issue.emit = odd_col && odd_row;
  assign issue.last = (row_count == row_last) && (column_count == col_last);

  // Hold the left texel of each pair
  always_ff @(posedge clk) begin
    if (rst) begin
      held_left_texel <= '0;
    end else if (accept && !odd_col) begin
      held_left_texel <= texel;
    end
  end

  // Advance column and row, wrap at the end of the level
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (column_count == col_last) begin
        column_count <= '0;
        if (row_count == row_last) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

// ===== src/mlbd_blend_out.sv =====
module mlbd_blend_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              take_last,
  input  mlbd_pkg::pair_t   pair,
  input  mlbd_pkg::pair_t   above,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output mlbd_pkg::texel_t  out_texel,
  output logic              out_last
);
  import mlbd_pkg::*;

  logic        s1_valid;
  logic        s1_last;
  pair_t       s1_pair;
  logic        s1_adv;
  texel_t      avg;
  logic [9:0]  sum_red;
  logic [9:0]  sum_green;
  logic [9:0]  sum_blue;
  logic [9:0]  sum_alpha;

  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign free   = !s1_valid || s1_adv;

  // Add the stored pair of the row above and drop two fraction bits
  always_comb begin
    sum_red   = {1'b0, above.red}   + {1'b0, s1_pair.red};
    sum_green = {1'b0, above.green} + {1'b0, s1_pair.green};
    sum_blue  = {1'b0, above.blue}  + {1'b0, s1_pair.blue};
    sum_alpha = {1'b0, above.alpha} + {1'b0, s1_pair.alpha};
    avg.red   = sum_red[9:2];
    avg.green = sum_green[9:2];
    avg.blue  = sum_blue[9:2];
    avg.alpha = sum_alpha[9:2];
  end

  // Hold the lower pair while the line store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (free) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (free && take) begin
      s1_pair <= pair;
      s1_last <= take_last;
    end
  end

  // Output register, drop the valid once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_texel <= avg;
      out_last  <= s1_last;
    end
  end

endmodule

// ===== src/mip_level_box_downsampler.sv =====
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  source texel
// m_axis    out        m_axis_tvalid/m_axis_tready  next level texel, tlast on final one
// cfg       in         cfg_valid/cfg_ready          register index and value
//
// One source texel per cycle while the output stage is free; the pair of the texel that
// closes a 2x2 block waits in the stage behind the output register while the line store is read.
// Reset clears counts and the held texel; the line store is not cleared.
// A stalled output holds one result in the output register and one in the
// stage behind it; input is refused only when both are full.
module mip_level_box_downsampler #(
  parameter int MAX_WIDTH = mlbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // red, green, blue, alpha
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                           m_axis_tlast,  // last_of_level
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mlbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlbd_pkg::CFG_W-1:0]     cfg_data
);
  import mlbd_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  logic [CFG_W-1:0]  source_width;
  logic [CFG_W-1:0]  source_height;
  logic              cfg_write;
  logic              restart;
  logic [COL_W-1:0]  col_last;
  logic [ROW_W-1:0]  row_last;
  logic              accept;
  issue_t            issue;
  pair_t             pair;
  pair_t             above;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] slot;
  logic              free;
  texel_t            out_texel;
  int                w_eff;
  int                h_eff;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write &&
                     (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= DIM_RESET;
      source_height <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions, round down to even, take the last index
  always_comb begin
    w_eff = int'(source_width);
    if (w_eff < 2) w_eff = 2;
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    w_eff = w_eff & ~1;
    h_eff = int'(source_height);
    if (h_eff < 2) h_eff = 2;
    if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
    h_eff = h_eff & ~1;
    col_last = COL_W'(w_eff - 1);
    row_last = ROW_W'(h_eff - 1);
  end

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mlbd_pair_front #(
    .COL_W  (COL_W),
    .ADDR_W (ADDR_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .texel    (texel_t'(s_axis_tdata)),
    .restart  (restart),
    .col_last (col_last),
    .row_last (row_last),
    .issue    (issue),
    .pair     (pair),
    .wr_en    (wr_en),
    .rd_en    (rd_en),
    .slot     (slot)
  );

  mlbd_line_ram #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (pair),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (above)
  );

  mlbd_blend_out u_blend (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && issue.emit),
    .take_last (issue.last),
    .pair      (pair),
    .above     (above),
    .free      (free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_texel (out_texel),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = out_texel;

endmodule

// ===== test/mip_level_box_downsampler_test.sv =====
`timescale 1ns / 1ps

module mip_level_box_downsampler_test;
  import mlbd_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int SETTLE       = 8;
  localparam int LONG_HOLD    = 300;
  localparam int LINE_SLOTS   = MAX_WIDTH_DEF / 2;

  typedef enum logic [1:0] {ROW_CFG, ROW_TEXEL, ROW_FILL} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

  typedef struct packed {
    texel_t px;
    logic   last;
  } block_result_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
    logic [11:0]          count;
    texel_t               px;
    logic                 typed;
    block_result_t        want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;   // red, green, blue, alpha
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;        // out_red, out_green, out_blue, out_alpha
  logic                 m_axis_tlast;        // last_of_level
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state
  logic [CFG_W-1:0] src_width  = DIM_RESET;
  logic [CFG_W-1:0] src_height = DIM_RESET;
  int               col_pos = 0;
  int               row_pos = 0;
  texel_t           held_left = '0;
  pair_t            pair_line [LINE_SLOTS];

  block_result_t    pending_blocks [$];
  int               mismatches = 0;
  int               burst_left = 0;
  int               hold_requests = 0;

  mip_level_box_downsampler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a size register, then round down to even
  function automatic int eff_dim(input logic [CFG_W-1:0] v, input int limit);
    int d;
    d = v;
    if (d < 2) d = 2;
    if (d > limit) d = limit;
    return d & ~1;
  endfunction

  // Advance the 2x2 box filter by one texel; return 1 when a block closes
  function automatic bit downsample_texel(input texel_t px, output block_result_t res);
    int    w;
    int    h;
    int    slot;
    pair_t pair;
    pair_t above;
    bit    emit;
    w    = eff_dim(src_width, MAX_WIDTH_DEF);
    h    = eff_dim(src_height, MAX_HEIGHT);
    slot = (col_pos >> 1) % LINE_SLOTS;
    emit = 1'b0;
    res  = '0;
    if (col_pos % 2 == 0) begin
      held_left = px;
    end else begin
      pair.red   = 9'(held_left.red)   + 9'(px.red);
      pair.green = 9'(held_left.green) + 9'(px.green);
      pair.blue  = 9'(held_left.blue)  + 9'(px.blue);
      pair.alpha = 9'(held_left.alpha) + 9'(px.alpha);
      if (row_pos % 2 == 0) begin
        pair_line[slot] = pair;
      end else begin
        above = pair_line[slot];
        res.px.red   = 8'((10'(above.red)   + 10'(pair.red))   >> 2);
        res.px.green = 8'((10'(above.green) + 10'(pair.green)) >> 2);
        res.px.blue  = 8'((10'(above.blue)  + 10'(pair.blue))  >> 2);
        res.px.alpha = 8'((10'(above.alpha) + 10'(pair.alpha)) >> 2);
        res.last     = (row_pos == h - 1) && (col_pos == w - 1);
        emit         = 1'b1;
      end
    end
    // Step raster position, wrap at end of level
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return emit;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_W-1:0] value);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.index = index;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t texel_row(input texel_t px);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_TEXEL;
    r.px   = px;
    return r;
  endfunction

  function automatic stim_row_t closing_row(input texel_t px, input texel_t want_px,
                                            input logic want_last);
    stim_row_t r;
    r           = texel_row(px);
    r.typed     = 1'b1;
    r.want.px   = want_px;
    r.want.last = want_last;
    return r;
  endfunction

  function automatic stim_row_t fill_row(input logic [11:0] count);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_FILL;
    r.count = count;
    return r;
  endfunction

  function automatic texel_t random_texel();
    texel_t px;
    px = $urandom;
    if ($urandom_range(0, 7) == 0) px = $urandom_range(0, 1) ? '1 : '0;
    return px;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Offer one texel, predict on the transaction, then maybe take a gap
  task automatic send_texel(input texel_t px, input logic typed, input block_result_t want);
    block_result_t res;
    int            gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
    if (downsample_texel(px, res)) begin
      if (typed) res = want;
      pending_blocks = {pending_blocks, res};
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every block is out and the pipeline has settled
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Known registers restart the level; unknown indexes change nothing
    if (index == REG_SOURCE_WIDTH || index == REG_SOURCE_HEIGHT) begin
      if (index == REG_SOURCE_WIDTH) src_width = value;
      else src_height = value;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  // Receiver: shifting stall patterns, plus a long hold on request
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       holds_served;
    int       tick;
    mode         = RX_OPEN;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    tick         = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:         m_axis_tready <= 1'b1;
          RX_COIN:         m_axis_tready <= 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: m_axis_tready <= (tick % 4 == 0);
          default:         m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Compare each output transaction with the oldest predicted block
  always @(posedge clk) begin : result_check
    block_result_t want;
    texel_t        got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = texel_t'(m_axis_tdata);
      if (pending_blocks.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_blocks.pop_front();
        check_field("out_red", want.px.red, got.red);
        check_field("out_green", want.px.green, got.green);
        check_field("out_blue", want.px.blue, got.blue);
        check_field("out_alpha", want.px.alpha, got.alpha);
        check_field("last_of_level", want.last, m_axis_tlast);
      end
    end
  end

  initial begin : run_limit
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    stim_row_t directed_rows [$];
    stim_row_t row;
    int        phase;
    int        sel;
    int        n;
    int        random_items;
    directed_rows = '{
      // Smallest image: all-zero and all-ones blocks, then a mixed one
      cfg_row(REG_SOURCE_WIDTH, 11'd2),
      cfg_row(REG_SOURCE_HEIGHT, 11'd2),
      texel_row(32'h0000_0000),
      texel_row(32'h0000_0000),
      texel_row(32'h0000_0000),
      closing_row(32'h0000_0000, 32'h0000_0000, 1'b1),
      texel_row(32'hFFFF_FFFF),
      texel_row(32'hFFFF_FFFF),
      texel_row(32'hFFFF_FFFF),
      closing_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
      texel_row(32'h0102_0304),
      texel_row(32'h807F_0100),
      texel_row(32'hFF00_FF00),
      texel_row(32'h00FF_00FF),
      // Sizes below range clamp up to two
      cfg_row(REG_SOURCE_WIDTH, 11'd0),
      cfg_row(REG_SOURCE_HEIGHT, 11'd1),
      fill_row(12'd4),
      // Odd sizes round down; a width write restarts the level mid-row
      cfg_row(REG_SOURCE_WIDTH, 11'd5),
      cfg_row(REG_SOURCE_HEIGHT, 11'd3),
      texel_row(32'h1234_5678),
      texel_row(32'hFEDC_BA98),
      cfg_row(REG_SOURCE_WIDTH, 11'd4),
      fill_row(12'd4),
      // Unknown register indexes leave the counts running
      cfg_row(8'hFF, 11'h7FF),
      cfg_row(8'h02, 11'h000),
      fill_row(12'd4),
      // Sizes above range clamp to the maximum; cross into the second row
      cfg_row(REG_SOURCE_WIDTH, 11'h7FF),
      cfg_row(REG_SOURCE_HEIGHT, 11'd2),
      fill_row(12'd1028),
      cfg_row(REG_SOURCE_WIDTH, 11'd2),
      cfg_row(REG_SOURCE_HEIGHT, 11'h7FF),
      fill_row(12'd8)
    };

    // Reset once
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CFG:   write_reg(row.index, row.value);
        ROW_TEXEL: send_texel(row.px, row.typed, row.want);
        default: begin
          repeat (row.count) send_texel(random_texel(), 1'b0, '0);
        end
      endcase
    end

    // Random images: mostly small even sizes, some odd, out of range or paused
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (phase == 0) begin
        // Fill the block while the receiver holds off
        write_reg(REG_SOURCE_WIDTH, 11'd16);
        write_reg(REG_SOURCE_HEIGHT, 11'd16);
        hold_requests++;
        n = 256;
      end else begin
        if (sel < 14) begin
          write_reg(REG_SOURCE_WIDTH, 11'(2 * $urandom_range(1, 12)));
          write_reg(REG_SOURCE_HEIGHT, 11'(2 * $urandom_range(1, 6)));
        end else if (sel < 17) begin
          write_reg(REG_SOURCE_WIDTH, 11'($urandom_range(0, 25)));
          write_reg(REG_SOURCE_HEIGHT, 11'($urandom_range(0, 13)));
        end else if (sel == 17) begin
          write_reg(REG_SOURCE_WIDTH, 11'($urandom_range(0, 2047)));
          write_reg(REG_SOURCE_HEIGHT, 11'($urandom_range(0, 2047)));
        end else if (sel == 18) begin
          write_reg(8'($urandom_range(2, 255)), 11'($urandom));
        end else begin
          drain_results();
        end
        n = eff_dim(src_width, MAX_WIDTH_DEF) * eff_dim(src_height, MAX_HEIGHT)
            * $urandom_range(1, 2);
        if (n > 400) n = $urandom_range(1, 400);
        else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      end
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      repeat (n) send_texel(random_texel(), 1'b0, '0);
      random_items += n;
      phase++;
    end

    // Drain and report
    drain_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mlbd_pkg.sv
src/mlbd_line_ram.sv
src/mlbd_pair_front.sv
src/mlbd_blend_out.sv
src/mip_level_box_downsampler.sv
test/mip_level_box_downsampler_test.sv
